// ===== hdl/ple_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int FUNC_W      = 3;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 4;
  localparam int COUNT_W     = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_HEAD = 3'd0,
    FN_INS_TAIL = 3'd1,
    FN_INS_POS  = 3'd2,
    FN_REM_HEAD = 3'd3,
    FN_REM_TAIL = 3'd4,
    FN_REM_POS  = 3'd5,
    FN_DUMP     = 3'd6,
    FN_DUMP_REV = 3'd7
  } func_t;

  typedef struct packed {
    logic capture;
    logic mutate;
    logic dump_first;
    logic dump_next;
  } cmd_t;

  typedef struct packed {
    logic is_dump;
    logic res_last;
  } sts_t;

endpackage

// ===== hdl/ple_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_if
// Request and result channels of the positional list engine.
// ----------------------------------------------------------------------------
interface ple_in_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::FUNC_W-1:0]        func;
  logic signed [ple_pkg::VALUE_W-1:0] item_value;
  logic [ple_pkg::POS_W-1:0]         position;

  modport source (output valid, func, item_value, position, input ready);
  modport sink   (input valid, func, item_value, position, output ready);
endinterface

interface ple_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [ple_pkg::VALUE_W-1:0] out_value;
  logic                              last;
  logic [ple_pkg::COUNT_W-1:0]       count;

  modport source (output valid, ok, out_value, last, count, input ready);
  modport sink   (input valid, ok, out_value, last, count, output ready);
endinterface

// ===== hdl/positional_list_engine.sv =====
`timescale 1ns / 1ps
// Insert/remove: the item is taken, then the cell chain shifts and the result register
// loads, then the result is offered; no new item is taken until that result is taken.
// Dump: the first result is loaded from the cell read mux after accept, then one per
// cycle while results are taken; min(count,16) results, or one with ok low if empty.
// Reset (synchronous, rst high) empties the list; stored values are not cleared.
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with positional insert, remove, dump.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);

  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ple_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_ch.func),
    .in_value  (in_ch.item_value),
    .in_pos    (in_ch.position),
    .res_ok    (out_ch.ok),
    .res_value (out_ch.out_value),
    .res_last  (out_ch.last),
    .res_count (out_ch.count)
  );

endmodule

// ===== hdl/ple_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer: takes an item, runs one operation or a dump, hands out results.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ple_pkg::cmd_t cmd,
  input  ple_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_dump) begin
          cmd.dump_first = 1'b1;
        end else begin
          cmd.mutate = 1'b1;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.res_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.dump_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_EXEC))
    else $error("capture not followed by execute");
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> out_valid)
    else $error("no result after execute");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && sts.res_last) |=> in_ready)
    else $error("not ready after last result");
`endif

endmodule

// ===== hdl/ple_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_dpath
// Cell chain with shift insert/remove, element count and result register.
// ----------------------------------------------------------------------------
module ple_dpath #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ple_pkg::cmd_t                       cmd,
  output ple_pkg::sts_t                       sts,
  input  logic [ple_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [ple_pkg::VALUE_W-1:0]  in_value,
  input  logic [ple_pkg::POS_W-1:0]           in_pos,
  output logic                                res_ok,
  output logic signed [ple_pkg::VALUE_W-1:0]  res_value,
  output logic                                res_last,
  output logic [ple_pkg::COUNT_W-1:0]         res_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int XW = (CW > ple_pkg::COUNT_W) ? CW : ple_pkg::COUNT_W;
  localparam int KW = $clog2(ple_pkg::MAX_RESULTS);

  ple_pkg::func_t                     f_r;
  logic signed [ple_pkg::VALUE_W-1:0] v_r;
  logic [ple_pkg::POS_W-1:0]          p_r;
  logic [CW-1:0]                      cnt;
  logic [ple_pkg::VALUE_W-1:0]        cells      [DEPTH];
  logic [ple_pkg::VALUE_W-1:0]        cells_next [DEPTH];
  logic [KW-1:0]                      kk;

  logic [CW-1:0] cnt_next;
  logic [XW-1:0] cnt_x, cnt_next_x, pos_x, ins_idx, rem_idx, k_x, rd_idx;
  logic          op_ins, op_ok, ins_en, rem_en, is_rev, dump_ld;
  logic [KW-1:0] knext;
  logic [ple_pkg::COUNT_W-1:0] n_res;

  assign cnt_x  = XW'(cnt);
  assign pos_x  = XW'(p_r);
  assign is_rev = (f_r == ple_pkg::FN_DUMP_REV);
  assign sts.is_dump  = (f_r == ple_pkg::FN_DUMP) || is_rev;
  assign sts.res_last = res_last;

  always_comb begin
    op_ins  = 1'b0;
    op_ok   = 1'b0;
    ins_idx = '0;
    rem_idx = '0;
    case (f_r)
      ple_pkg::FN_INS_HEAD: begin
        op_ins = 1'b1;
        op_ok  = (cnt_x < XW'(DEPTH));
      end
      ple_pkg::FN_INS_TAIL: begin
        op_ins  = 1'b1;
        op_ok   = (cnt_x < XW'(DEPTH));
        ins_idx = cnt_x;
      end
      ple_pkg::FN_INS_POS: begin
        op_ins  = 1'b1;
        op_ok   = (cnt_x < XW'(DEPTH)) && (pos_x < cnt_x);
        ins_idx = pos_x;
      end
      ple_pkg::FN_REM_HEAD: begin
        op_ok = (cnt_x != '0);
      end
      ple_pkg::FN_REM_TAIL: begin
        op_ok   = (cnt_x != '0);
        rem_idx = cnt_x - XW'(1);
      end
      ple_pkg::FN_REM_POS: begin
        op_ok   = (pos_x < cnt_x);
        rem_idx = pos_x;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  assign ins_en     = cmd.mutate && op_ok && op_ins;
  assign rem_en     = cmd.mutate && op_ok && !op_ins;
  assign cnt_next   = op_ins ? CW'(cnt + 1'b1) : CW'(cnt - 1'b1);
  assign cnt_next_x = XW'(cnt_next);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_next[i] = cells[i];
      if (ins_en) begin
        if (XW'(i) > ins_idx) begin
          cells_next[i] = cells[(i > 0) ? i - 1 : 0];
        end else if (XW'(i) == ins_idx) begin
          cells_next[i] = v_r;
        end
      end else if (rem_en) begin
        if ((XW'(i) >= rem_idx) && (i < DEPTH - 1)) begin
          cells_next[i] = cells[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  // dump read path
  assign dump_ld = cmd.dump_first || cmd.dump_next;
  assign knext   = cmd.dump_first ? '0 : KW'(kk + 1'b1);
  assign k_x     = XW'(knext);
  assign rd_idx  = is_rev ? (cnt_x - XW'(1) - k_x) : k_x;
  assign n_res   = (cnt_x >= XW'(ple_pkg::MAX_RESULTS)) ?
                   ple_pkg::COUNT_W'(ple_pkg::MAX_RESULTS) : cnt_x[ple_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.mutate && op_ok) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      f_r <= ple_pkg::func_t'(in_func);
      v_r <= in_value;
      p_r <= in_pos;
    end
    for (int i = 0; i < DEPTH; i++) begin
      cells[i] <= cells_next[i];
    end
    if (dump_ld) begin
      kk <= knext;
    end
    if (cmd.mutate) begin
      res_ok    <= op_ok;
      res_value <= '0;
      res_last  <= 1'b1;
      res_count <= op_ok ? cnt_next_x[ple_pkg::COUNT_W-1:0] : cnt_x[ple_pkg::COUNT_W-1:0];
    end else if (dump_ld) begin
      res_count <= cnt_x[ple_pkg::COUNT_W-1:0];
      if (n_res == '0) begin
        res_ok    <= 1'b0;
        res_value <= '0;
        res_last  <= 1'b1;
      end else begin
        res_ok    <= 1'b1;
        res_value <= cells[rd_idx[IW-1:0]];
        res_last  <= ((ple_pkg::COUNT_W'(knext) + 1'b1) == n_res);
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(cnt) <= XW'(DEPTH))
    else $error("element count above depth");
`endif

endmodule
